FILE: hdl/swm_pkg.sv
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Width and reset value of the window size register.
   localparam int CFG_BITS = 7;
   localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd3;

   // Controls broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic step;    // a sample beat is accepted this cycle
      logic first;   // that sample starts a new sequence
      logic drop;    // the front entry leaves the window on this step
      logic pop;     // purge one stale front entry, no sample taken
   } swm_ctl_type;

endpackage

FILE: hdl/swm_req_if.sv
interface swm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          first;
   logic                          last;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, first, last, sample, input ready);
   modport sink   (input valid, first, last, sample, output ready);
endinterface

FILE: hdl/swm_rsp_if.sv
interface swm_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;
   logic                          end_of_run;

   modport source (output valid, window_max, end_of_run, input ready);
   modport sink   (input valid, window_max, end_of_run, output ready);
endinterface

FILE: hdl/sliding_window_maximum_unit.sv
// Running maximum over the latest window_size (at most WINDOW_MAX) signed samples.
// Samples arrive as beats on req_if (first, last, sample); results leave as
// beats on rsp_if (window_max, end_of_run). A beat moves when valid and ready
// are both high. first starts a new sequence; end_of_run copies last.
// One result follows each sample once window_size samples (at most WINDOW_MAX)
// of the sequence have been seen; a window size of zero gives no results at all.
// The deque lives in a row of WINDOW_MAX cells, front at cell 0. Each cell
// compares its entry with the new sample in parallel, so one sample is taken
// per cycle unless stalled, and its result is written into the output register.
// After the window is made shorter, stale front entries are purged one per
// cycle before the next sample is taken.
// When the receiver stalls, the output register holds its result and the
// block takes no further sample until that result has gone.
// Reset (synchronous, active high) empties the deque, clears the fill count
// and sets window_size to 3. csr_write_enable writes window_size at once;
// write it only while no sample is in flight.
module sliding_window_maximum_unit
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   swm_req_if.sink             req_if,
   swm_rsp_if.source           rsp_if,
   input  logic                csr_write_enable,
   input  logic [CFG_BITS-1:0] csr_write_data
);

   localparam int AGE_BITS = $clog2(WINDOW_MAX + 1);
   localparam int K_BITS   = (AGE_BITS > CFG_BITS) ? AGE_BITS : CFG_BITS;

   logic [CFG_BITS-1:0]           window_size_ff;
   logic [AGE_BITS-1:0]           fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic                          rsp_end_ff, rsp_end_in;

   logic [K_BITS-1:0]             size_wide;
   logic [AGE_BITS-1:0]           k_eff;
   logic                          purge, accept, emit;
   logic signed [SAMPLE_BITS-1:0] front_value;
   swm_ctl_type                   ctl;

   logic                          cell_valid [0:WINDOW_MAX];
   logic                          cell_keep  [0:WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] cell_value [0:WINDOW_MAX];
   logic [AGE_BITS-1:0]           cell_age   [0:WINDOW_MAX];
   logic                          chain_keep [0:WINDOW_MAX];

   // Window length saturated to the depth of the chain.
   assign size_wide = K_BITS'(window_size_ff);
   assign k_eff     = (size_wide > K_BITS'(WINDOW_MAX)) ? AGE_BITS'(WINDOW_MAX)
                                                        : AGE_BITS'(size_wide);

   // Beyond the back of the chain sits a permanently empty place.
   assign cell_valid[WINDOW_MAX] = 1'b0;
   assign cell_keep[WINDOW_MAX]  = 1'b0;
   assign cell_value[WINDOW_MAX] = '0;
   assign cell_age[WINDOW_MAX]   = '0;
   assign chain_keep[0]          = 1'b1;

   // Ages fall strictly from front to back, so stale entries form a prefix. With
   // an unchanged window at most the front one is stale; more than that means
   // the window was shortened, and those are purged before a sample is taken.
   assign ctl.drop = cell_valid[0] && (cell_age[0] >= k_eff);
   assign purge    = ctl.drop && cell_valid[1] && (cell_age[1] >= k_eff);
   assign req_if.ready = !purge && (!rsp_valid_ff || rsp_if.ready);
   assign accept   = req_if.valid && req_if.ready;
   assign ctl.step  = accept;
   assign ctl.first = req_if.first;
   assign ctl.pop   = purge;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .sample        (req_if.sample),
         .prev_src_keep (chain_keep[i]),
         .up_valid      (cell_valid[i+1]),
         .up_keep       (cell_keep[i+1]),
         .up_value      (cell_value[i+1]),
         .up_age        (cell_age[i+1]),
         .valid         (cell_valid[i]),
         .keep          (cell_keep[i]),
         .src_keep      (chain_keep[i+1]),
         .value         (cell_value[i]),
         .age           (cell_age[i])
      );
   end

   // The new front is the surviving entry that lands in cell 0, or the sample.
   assign front_value = chain_keep[1] ? (ctl.drop ? cell_value[1] : cell_value[0])
                                      : req_if.sample;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_if.first) begin
            fill_in = AGE_BITS'(1);
         end else if (fill_ff < AGE_BITS'(WINDOW_MAX)) begin
            fill_in = fill_ff + AGE_BITS'(1);
         end
      end
   end

   assign emit = (k_eff != '0) && (fill_in >= k_eff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_end_in   = rsp_end_ff;
      if (accept) begin
         rsp_valid_in = emit;
         rsp_max_in   = front_value;
         rsp_end_in   = req_if.last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
         end
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_max_ff <= rsp_max_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.window_max = rsp_max_ff;
   assign rsp_if.end_of_run = rsp_end_ff;

endmodule

FILE: hdl/swm_cell.sv
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int AGE_BITS    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_ctl_type                   ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          prev_src_keep,
   input  logic                          up_valid,
   input  logic                          up_keep,
   input  logic signed [SAMPLE_BITS-1:0] up_value,
   input  logic [AGE_BITS-1:0]           up_age,
   output logic                          valid,
   output logic                          keep,
   output logic                          src_keep,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AGE_BITS-1:0]           age
);

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AGE_BITS-1:0]           age_ff, age_in;
   logic signed [SAMPLE_BITS-1:0] src_value;
   logic [AGE_BITS-1:0]           src_age;

   // An entry survives the back discard unless it is strictly below the new sample.
   assign keep = valid_ff && !(value_ff < sample);

   // The entry that would land here: our own, or our upstream neighbour's when
   // the front leaves the window and the whole deque moves one place forward.
   assign src_keep  = !ctl.first && (ctl.drop ? up_keep : keep);
   assign src_value = ctl.drop ? up_value : value_ff;
   assign src_age   = ctl.drop ? up_age : age_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      if (ctl.pop) begin
         valid_in = up_valid;
         value_in = up_value;
         age_in   = up_age;
      end else if (ctl.step) begin
         if (src_keep) begin
            valid_in = 1'b1;
            value_in = src_value;
            age_in   = src_age + AGE_BITS'(1);
         end else if (prev_src_keep) begin
            // First free place behind the surviving entries takes the new sample.
            valid_in = 1'b1;
            value_in = sample;
            age_in   = AGE_BITS'(1);
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule
